// File: hw/rtl/hpm_pkg.sv
// Shared types, codes and defaults of the half-plane polygon pixel mask.
`default_nettype none

package hpm_pkg;

    localparam int COORD_W        = 12;
    localparam int CHAN_W         = 8;
    localparam int OP_W           = 2;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 16;
    localparam int MAX_LINES_DEF  = 16;
    localparam int COORD_BITS_DEF = 12;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_PIXEL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ROW = 8'd1;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [COORD_W-1:0] pixel_row;
        logic [COORD_W-1:0] pixel_col;
        logic [CHAN_W-1:0]  chan0_in;
        logic [CHAN_W-1:0]  chan1_in;
        logic [CHAN_W-1:0]  chan2_in;
    } hpm_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] chan0_out;
        logic [CHAN_W-1:0] chan1_out;
        logic [CHAN_W-1:0] chan2_out;
        logic              pixel_cleared;
        logic              table_full;
    } hpm_out_t;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_CLEAR,
        KIND_PIXEL,
        KIND_NOP
    } kind_t;

    // Classified request as it sits in the queue between front and back.
    typedef struct packed {
        kind_t              kind;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [CHAN_W-1:0]  c0;
        logic [CHAN_W-1:0]  c1;
        logic [CHAN_W-1:0]  c2;
    } hpm_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD1,
        ST_LD2,
        ST_LD3,
        ST_LD4,
        ST_PX,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/hpm_front.sv
// Front end: accepts requests and classifies them by opcode.
`default_nettype none

module hpm_front
    import hpm_pkg::*;
(
    input  wire logic     cmd_valid,
    output logic          cmd_ready,
    input  wire hpm_in_t  cmd,
    output logic          push,
    output hpm_cmd_t      entry,
    input  wire logic     q_ready
);

    assign cmd_ready = q_ready;
    assign push      = cmd_valid && q_ready;

    // Only the fields that the request kind needs are carried on.
    always_comb
    begin
        entry = '0;
        case (cmd.opcode)
            OP_LOAD:
            begin
                entry.kind = KIND_LOAD;
                entry.sx   = cmd.start_x;
                entry.sy   = cmd.start_y;
                entry.ex   = cmd.end_x;
                entry.ey   = cmd.end_y;
            end
            OP_CLEAR:
            begin
                entry.kind = KIND_CLEAR;
            end
            OP_PIXEL:
            begin
                entry.kind = KIND_PIXEL;
                entry.row  = cmd.pixel_row;
                entry.col  = cmd.pixel_col;
                entry.c0   = cmd.chan0_in;
                entry.c1   = cmd.chan1_in;
                entry.c2   = cmd.chan2_in;
            end
            default:
            begin
                entry.kind = KIND_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/hpm_queue.sv
// Two-entry queue that decouples the front end from the back end.
`default_nettype none

module hpm_queue
    import hpm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire hpm_cmd_t entry,
    output logic          in_ready,
    output logic          out_valid,
    output hpm_cmd_t      head,
    input  wire logic     pop
);

    hpm_cmd_t   slot_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign head      = slot_reg[rd_reg];
    assign do_push   = push && in_ready;
    assign do_pop    = pop && out_valid;

    always_comb
    begin
        wr_next  = do_push ? ~wr_reg : wr_reg;
        rd_next  = do_pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= entry;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/hpm_back.sv
// Back end: line table, coefficient pipeline, per-line pixel test and result register.
`default_nettype none

module hpm_back
    import hpm_pkg::*;
#(
    parameter int MAX_LINES  = MAX_LINES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    input  wire hpm_cmd_t              q_cmd,
    output logic                       q_pop,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output hpm_out_t                   res
);

    localparam int CB  = COORD_BITS;
    localparam int AW  = CB + 1;
    localparam int PW  = 2 * CB;
    localparam int CWD = 2 * CB + 1;
    localparam int MW  = AW + CFG_DATA_W + 1;
    localparam int SW  = ((MW > CWD + 4) ? MW : CWD + 4) + 2;
    localparam int PVW = AW + CB + 1;
    localparam int VW  = 2 * CB + 3;
    localparam int NW  = $clog2(MAX_LINES + 1);
    localparam int IW  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

    state_t state_reg, state_next;
    logic [NW-1:0] count_reg, count_next;
    logic [NW-1:0] iss_reg;
    logic          s1_valid_reg, s2_valid_reg;
    logic          clr_reg;
    logic          res_valid_reg;
    hpm_out_t      res_reg;
    hpm_out_t      pend_reg, pend_next;
    logic          res_load;
    logic [CFG_DATA_W-1:0] ccol_reg, crow_reg;

    logic [CB-1:0] sx_reg, sy_reg, ex_reg, ey_reg, row_reg, col_reg;
    logic [CHAN_W-1:0] c0_reg, c1_reg, c2_reg;

    logic signed [AW-1:0]  a_reg, b_reg;
    logic [PW-1:0]         p1_reg, p2_reg;
    logic signed [CWD-1:0] c_reg;
    logic signed [MW-1:0]  ma_reg, mb_reg;
    logic signed [SW-1:0]  s_reg;
    logic signed [SW-1:0]  v_load;
    logic                  side_load;

    logic signed [AW-1:0]  mem_a [MAX_LINES];
    logic signed [AW-1:0]  mem_b [MAX_LINES];
    logic signed [CWD-1:0] mem_c [MAX_LINES];
    logic                  mem_side [MAX_LINES];

    logic signed [AW-1:0]  rd_a_reg, rd_b_reg;
    logic signed [CWD-1:0] rd_c_reg;
    logic                  rd_side_reg;
    logic signed [PVW-1:0] pa_reg, pb_reg;
    logic signed [CWD-1:0] c2_stage_reg;
    logic                  side2_reg;
    logic signed [VW-1:0]  v_pix;
    logic                  out_side;

    logic table_is_full, issue, px_done, mem_we, take;

    assign table_is_full = (count_reg >= NW'(MAX_LINES));
    assign issue   = (state_reg == ST_PX) && (iss_reg < count_reg);
    assign px_done = (iss_reg == count_reg) && !s1_valid_reg && !s2_valid_reg;
    assign mem_we  = (state_reg == ST_LD4);
    assign take    = (state_reg == ST_IDLE) && q_valid;

    // Sign of sixteen times the line value at the center.
    assign v_load    = s_reg + SW'(mb_reg);
    assign side_load = !v_load[SW-1] && (v_load != '0);

    // Line value at the pixel and the strict far-side test.
    assign v_pix    = VW'(pa_reg) + VW'(pb_reg) + VW'(c2_stage_reg);
    assign out_side = side2_reg ? v_pix[VW-1] : (!v_pix[VW-1] && (v_pix != '0));

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pend_next  = pend_reg;
        q_pop      = 1'b0;
        res_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                q_pop = 1'b1;
                if (q_valid)
                begin
                    pend_next = '0;
                    case (q_cmd.kind)
                        KIND_LOAD:
                        begin
                            if (table_is_full)
                            begin
                                pend_next.table_full = 1'b1;
                                state_next = ST_RESULT;
                            end
                            else
                            begin
                                state_next = ST_LD1;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                            state_next = ST_RESULT;
                        end
                        KIND_PIXEL:
                        begin
                            state_next = ST_PX;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_LD1: state_next = ST_LD2;
            ST_LD2: state_next = ST_LD3;
            ST_LD3: state_next = ST_LD4;
            ST_LD4:
            begin
                count_next = count_reg + 1'b1;
                state_next = ST_RESULT;
            end
            ST_PX:
            begin
                if (px_done)
                begin
                    pend_next.chan0_out     = clr_reg ? '0 : c0_reg;
                    pend_next.chan1_out     = clr_reg ? '0 : c1_reg;
                    pend_next.chan2_out     = clr_reg ? '0 : c2_reg;
                    pend_next.pixel_cleared = clr_reg;
                    pend_next.table_full    = 1'b0;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            iss_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            clr_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            ccol_reg      <= '0;
            crow_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            if (take)
            begin
                iss_reg <= '0;
                clr_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    iss_reg <= iss_reg + 1'b1;
                end
                if (s2_valid_reg && out_side)
                begin
                    clr_reg <= 1'b1;
                end
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (cfg_valid && (cfg_index == CFG_CENTER_COL))
            begin
                ccol_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == CFG_CENTER_ROW))
            begin
                crow_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (res_load)
        begin
            res_reg <= pend_reg;
        end
        if (take)
        begin
            sx_reg  <= CB'(q_cmd.sx);
            sy_reg  <= CB'(q_cmd.sy);
            ex_reg  <= CB'(q_cmd.ex);
            ey_reg  <= CB'(q_cmd.ey);
            row_reg <= CB'(q_cmd.row);
            col_reg <= CB'(q_cmd.col);
            c0_reg  <= q_cmd.c0;
            c1_reg  <= q_cmd.c1;
            c2_reg  <= q_cmd.c2;
        end
        if (state_reg == ST_LD1)
        begin
            a_reg  <= $signed({1'b0, ey_reg}) - $signed({1'b0, sy_reg});
            b_reg  <= $signed({1'b0, sx_reg}) - $signed({1'b0, ex_reg});
            p1_reg <= ex_reg * sy_reg;
            p2_reg <= sx_reg * ey_reg;
        end
        if (state_reg == ST_LD2)
        begin
            c_reg  <= $signed({1'b0, p1_reg}) - $signed({1'b0, p2_reg});
            ma_reg <= a_reg * $signed({1'b0, ccol_reg});
        end
        if (state_reg == ST_LD3)
        begin
            mb_reg <= b_reg * $signed({1'b0, crow_reg});
            s_reg  <= SW'(ma_reg) + (SW'(c_reg) <<< 4);
        end
        if (s1_valid_reg)
        begin
            pa_reg       <= rd_a_reg * $signed({1'b0, col_reg});
            pb_reg       <= rd_b_reg * $signed({1'b0, row_reg});
            c2_stage_reg <= rd_c_reg;
            side2_reg    <= rd_side_reg;
        end
    end

    // Line table: one write port for loads, one registered read port for tests.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_a[count_reg[IW-1:0]]    <= a_reg;
            mem_b[count_reg[IW-1:0]]    <= b_reg;
            mem_c[count_reg[IW-1:0]]    <= c_reg;
            mem_side[count_reg[IW-1:0]] <= side_load;
        end
        if (issue)
        begin
            rd_a_reg    <= mem_a[iss_reg[IW-1:0]];
            rd_b_reg    <= mem_b[iss_reg[IW-1:0]];
            rd_c_reg    <= mem_c[iss_reg[IW-1:0]];
            rd_side_reg <= mem_side[iss_reg[IW-1:0]];
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// File: hw/rtl/half_plane_polygon_pixel_mask.sv
// Top level of the half-plane polygon pixel mask.
//
// Requests arrive on the cmd channel (valid/ready) and each one gives exactly
// one result on the res channel (valid/ready), in request order. A load request
// turns a segment into line coefficients and stores them together with the side
// of the line on which the configured center lies; a clear request empties the
// table; a pixel request passes the pixel or zeroes it when it lies strictly on
// the far side of any stored line. Loads beyond MAX_LINES are dropped and flagged.
// The cfg channel writes the center column and row; it is always ready and must
// only be used while the block is idle.
// A front end classifies requests into a two-entry queue, so up to two requests
// are taken while the back end is busy. From the queue head, a load runs through
// four stages of coefficient and center-side arithmetic, and a pixel tests the
// stored lines in turn: the line table has one read port and one line is tested
// per cycle. Each request is registered in the queue before the back end takes it.
// Reset empties the table and the queue and zeroes the center. When the receiver
// stalls, the result register holds its value and the back end waits only once
// it has a further result to deliver.
`default_nettype none

module half_plane_polygon_pixel_mask
    import hpm_pkg::*;
#(
    parameter int MAX_LINES  = MAX_LINES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    output logic                       cmd_ready,
    input  wire hpm_in_t               cmd,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output hpm_out_t                   res,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic     push;
    hpm_cmd_t entry;
    logic     q_ready;
    logic     q_valid;
    hpm_cmd_t q_head;
    logic     q_pop;

    // Configuration writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    hpm_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .push      (push),
        .entry     (entry),
        .q_ready   (q_ready)
    );

    hpm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .entry     (entry),
        .in_ready  (q_ready),
        .out_valid (q_valid),
        .head      (q_head),
        .pop       (q_pop)
    );

    hpm_back #(
        .MAX_LINES  (MAX_LINES),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_head),
        .q_pop     (q_pop),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

`default_nettype wire

// File: hw/rtl/hpm_checker.sv
// Port-level checks on the pixel mask results, bound to the top level.
`default_nettype none

module hpm_checker
    import hpm_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     res_valid,
    input wire logic     res_ready,
    input wire hpm_out_t res
);

    // A stalled result stays put.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed or dropped while stalled");

    // A result never flags both a dropped load and a cleared pixel.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.pixel_cleared && res.table_full))
        else $error("pixel_cleared and table_full both set");

    // A cleared pixel carries no color.
    a_cleared_black: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.pixel_cleared |->
            res.chan0_out == '0 && res.chan1_out == '0 && res.chan2_out == '0)
        else $error("cleared pixel has nonzero channels");

    // A dropped load carries no color.
    a_full_black: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.table_full |->
            res.chan0_out == '0 && res.chan1_out == '0 && res.chan2_out == '0)
        else $error("dropped load has nonzero channels");

endmodule

bind half_plane_polygon_pixel_mask hpm_checker u_checker (.*);

`default_nettype wire
